>>> hdl/egcd_pkg.sv
package egcd_pkg;

    localparam int OPER_W = 31;
    localparam int COEF_W = 32;

    typedef struct packed {
        logic [OPER_W-1:0] operand_a;
        logic [OPER_W-1:0] operand_b;
    } egcd_in_t;

    typedef struct packed {
        logic [OPER_W-1:0]        gcd_value;
        logic signed [COEF_W-1:0] coeff_x;
        logic signed [COEF_W-1:0] coeff_y;
    } egcd_out_t;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CHECK = 5'b00010,
        ST_DIV   = 5'b00100,
        ST_MULS  = 5'b01000,
        ST_MULT  = 5'b10000
    } egcd_state_t;

endpackage

>>> hdl/egcd_div.sv
module egcd_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [egcd_pkg::OPER_W-1:0]  dividend,
    input  logic [egcd_pkg::OPER_W-1:0]  divisor,
    output logic                         done,
    output logic [egcd_pkg::OPER_W-1:0]  quotient,
    output logic [egcd_pkg::OPER_W-1:0]  remainder
);
    import egcd_pkg::*;

    localparam int CNT_W = $clog2(OPER_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [OPER_W-1:0] rem_reg;
    logic [OPER_W-1:0] quo_reg;
    logic [OPER_W-1:0] dvs_reg;

    logic [OPER_W:0]   shifted;
    logic [OPER_W:0]   diff;
    logic              ge;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        shifted = {rem_reg, quo_reg[OPER_W-1]};
        diff    = shifted - {1'b0, dvs_reg};
        ge      = (shifted >= {1'b0, dvs_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(OPER_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[OPER_W-1:0] : shifted[OPER_W-1:0];
            quo_reg <= {quo_reg[OPER_W-2:0], ge};
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

>>> hdl/egcd_mul.sv
module egcd_mul (
    input  logic                         clk,
    input  logic [egcd_pkg::COEF_W-1:0]  mul_a,
    input  logic [egcd_pkg::COEF_W-1:0]  mul_b,
    output logic [egcd_pkg::COEF_W-1:0]  product
);
    import egcd_pkg::*;

    logic [COEF_W-1:0] prod_reg;

    // low half only: coefficients are kept modulo 2^32
    always_ff @(posedge clk)
    begin
        prod_reg <= COEF_W'(mul_a * mul_b);
    end

    assign product = prod_reg;

endmodule

>>> hdl/extended_gcd_core.sv
// Channel   Handshake             Payload      Beat taken when
// -------   -------------------   ----------   -------------------------
// operands  start / busy          egcd_in_t    start high, busy low
// result    done (strobe)         egcd_out_t   every cycle done is high
//
// One beat runs N Euclid steps, N at most about 45 for 31-bit operands. Each
// step runs the bit-serial divider, then uses the shared multiplier twice and
// closes the step in the first CHECK after MULT.
// busy is high from the accepted beat and drops in the cycle done is high.
// Reset clears the sequencer only. done lasts one cycle and cannot stall.
module extended_gcd_core #(
    parameter int WORD_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  egcd_pkg::egcd_in_t   operands,
    output logic                 done,
    output egcd_pkg::egcd_out_t  result
);
    import egcd_pkg::*;

    localparam int STEP_LIMIT = 2 * WORD_BITS;
    localparam int STEP_W     = $clog2(STEP_LIMIT + 1);
    localparam logic [OPER_W-1:0] GCD_MASK =
        (WORD_BITS >= OPER_W) ? {OPER_W{1'b1}} : OPER_W'((64'd1 << WORD_BITS) - 64'd1);

    egcd_state_t       state_reg, state_next;
    logic [STEP_W-1:0] steps_reg;
    logic [OPER_W-1:0] r0_reg, r1_reg;
    logic [COEF_W-1:0] s0_reg, s1_reg, t0_reg, t1_reg;
    logic [COEF_W-1:0] ns_reg;
    logic              done_reg;
    egcd_out_t         result_reg;
    logic              mult_pending_reg;

    logic              div_start;
    logic              div_done;
    logic [OPER_W-1:0] div_quo, div_rem;
    logic [COEF_W-1:0] mul_a, mul_b, mul_p;
    logic              finish;

    assign finish = (r1_reg == '0) || (steps_reg == STEP_W'(STEP_LIMIT));

    egcd_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (r0_reg),
        .divisor   (r1_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // multiplier sees q*s1 in MULS, q*t1 in MULT; the product is registered
    always_comb
    begin
        mul_a = {1'b0, div_quo};
        mul_b = (state_reg == ST_MULS) ? s1_reg : t1_reg;
    end

    egcd_mul u_mul (
        .clk     (clk),
        .mul_a   (mul_a),
        .mul_b   (mul_b),
        .product (mul_p)
    );

    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                // first CHECK after MULT only closes the step
                if (!mult_pending_reg)
                begin
                    if (finish)
                        state_next = ST_IDLE;
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_MULS;
            end
            ST_MULS:
            begin
                state_next = ST_MULT;
            end
            ST_MULT:
            begin
                state_next = ST_CHECK;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_CHECK) && !mult_pending_reg && finish;
        end
    end

    // the product of MULS is taken in MULT, the one of MULT at the next CHECK
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mult_pending_reg <= 1'b0;
        else
            mult_pending_reg <= (state_reg == ST_MULT);
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            r0_reg    <= operands.operand_a;
            r1_reg    <= operands.operand_b;
            s0_reg    <= COEF_W'(1);
            s1_reg    <= '0;
            t0_reg    <= '0;
            t1_reg    <= COEF_W'(1);
            steps_reg <= '0;
        end
        else if (state_reg == ST_MULT)
        begin
            ns_reg <= s0_reg - mul_p;
        end
        else if (mult_pending_reg)
        begin
            // product is q*t1; close the Euclid step
            r0_reg    <= r1_reg;
            r1_reg    <= div_rem;
            s0_reg    <= s1_reg;
            s1_reg    <= ns_reg;
            t0_reg    <= t1_reg;
            t1_reg    <= t0_reg - mul_p;
            steps_reg <= steps_reg + 1'b1;
        end

        if (state_reg == ST_CHECK && !mult_pending_reg && finish)
        begin
            result_reg.gcd_value <= r0_reg & GCD_MASK;
            result_reg.coeff_x   <= s0_reg;
            result_reg.coeff_y   <= t0_reg;
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule
